>>> rtl/core/max_heap_insert_defines.svh
// assertion macros for the max heap insert block
// needs a clock named clk and a reset named rst in the including module
`ifndef MAX_HEAP_INSERT_DEFINES_SVH
`define MAX_HEAP_INSERT_DEFINES_SVH

// same-cycle implication, checked outside reset
`define MHI_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define MHI_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/mhi_pkg.sv
// shared types and constants for the max heap insert block
// no dependencies
package mhi_pkg;

  localparam int KEY_W = 32;
  localparam int CAP_W = 11;

  typedef logic signed [KEY_W-1:0] key_t;

  // sift sequencer states
  typedef enum logic [1:0] {
    S_IDLE,
    S_CMP,
    S_PUT
  } sift_state_t;

  // per-item completion flags from the sequencer
  typedef struct packed {
    logic done;
    logic refused;
    logic at_root;
  } sift_flags_t;

endpackage

>>> rtl/core/mhi_ram.sv
// heap key storage: one write port, one read port, registered read data
// depends on mhi_pkg
module mhi_ram #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  logic            clk,
  input  logic            we,
  input  logic [AW-1:0]   waddr,
  input  mhi_pkg::key_t   wdata,
  input  logic [AW-1:0]   raddr,
  output mhi_pkg::key_t   rdata
);

  mhi_pkg::key_t mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port, registered read data
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/core/mhi_sift.sv
// sift-up sequencer: key count, current slot and read/modify/write of the heap ram
// depends on mhi_pkg and mhi_ram
module mhi_sift #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10,
  parameter int CW    = 11
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                accept,
  input  logic                full,
  input  mhi_pkg::key_t       key_in,
  output logic                busy,
  output logic [CW-1:0]       count,
  output mhi_pkg::sift_flags_t flags,
  output logic [AW-1:0]       res_slot,
  output mhi_pkg::key_t       res_key
);

  mhi_pkg::sift_state_t state, state_next;
  logic [CW-1:0]        count_next;
  logic [AW-1:0]        slot, slot_next;
  mhi_pkg::key_t        key, key_next;

  logic                 we;
  logic [AW-1:0]        waddr;
  mhi_pkg::key_t        wdata;
  logic [AW-1:0]        raddr;
  mhi_pkg::key_t        rdata;

  logic [AW-1:0]        parent;
  logic [AW-1:0]        grand;
  logic [CW-1:0]        count_dec;

  mhi_ram #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  // parent indexes of the current slot, of its parent and of the fill position
  assign parent    = (slot - 1'b1) >> 1;
  assign grand     = (parent - 1'b1) >> 1;
  assign count_dec = (count - 1'b1) >> 1;

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mhi_pkg::S_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    slot <= slot_next;
    key  <= key_next;
  end

  // next state, memory access and completion
  always_comb begin
    state_next    = state;
    count_next    = count;
    slot_next     = slot;
    key_next      = key;
    we            = 1'b0;
    waddr         = slot;
    wdata         = key;
    raddr         = parent;
    flags.done    = 1'b0;
    flags.refused = 1'b0;
    flags.at_root = 1'b0;
    res_slot      = slot;
    res_key       = key;
    unique case (state)
      mhi_pkg::S_IDLE: begin
        raddr = AW'(count_dec);
        if (accept) begin
          key_next = key_in;
          res_key  = key_in;
          if (full) begin
            // refused word, heap and count unchanged
            flags.done    = 1'b1;
            flags.refused = 1'b1;
            res_slot      = '0;
          end else if (count == '0) begin
            // first key goes straight to the root
            count_next    = count + 1'b1;
            we            = 1'b1;
            waddr         = '0;
            wdata         = key_in;
            slot_next     = '0;
            res_slot      = '0;
            flags.done    = 1'b1;
            flags.at_root = 1'b1;
          end else begin
            // read the parent of the fill slot and start climbing
            count_next = count + 1'b1;
            slot_next  = AW'(count);
            state_next = mhi_pkg::S_CMP;
          end
        end
      end
      mhi_pkg::S_CMP: begin
        if (key > rdata) begin
          // parent moves down, key climbs one level
          we        = 1'b1;
          waddr     = slot;
          wdata     = rdata;
          slot_next = parent;
          raddr     = grand;
          if (parent == '0) begin
            state_next = mhi_pkg::S_PUT;
          end
        end else begin
          // key rests here
          we         = 1'b1;
          waddr      = slot;
          wdata      = key;
          flags.done = 1'b1;
          state_next = mhi_pkg::S_IDLE;
        end
      end
      mhi_pkg::S_PUT: begin
        // key reached the root
        we            = 1'b1;
        waddr         = '0;
        wdata         = key;
        res_slot      = '0;
        flags.done    = 1'b1;
        flags.at_root = 1'b1;
        state_next    = mhi_pkg::S_IDLE;
      end
      default: begin
        state_next = mhi_pkg::S_IDLE;
      end
    endcase
  end

  assign busy = (state != mhi_pkg::S_IDLE);

endmodule

>>> rtl/core/max_heap_insert.sv
// top level of the max heap insert block: capacity register, result word, checks
// depends on mhi_pkg, mhi_sift, mhi_ram and max_heap_insert_defines.svh
//
//   channel   handshake            payload
//   -------   ------------------   -------------------------------------------
//   input     start / busy         key_value
//   result    done (one cycle)     insert_status, count_after, final_slot, max_key
//   config    cfg_write            capacity_in_use
//
// an insert runs from start through a compare per level climbed and then a final
// compare or root write; the root write takes the place of the final compare, so
// reaching the root costs the same. a refused or first key is finished from the
// idle state with no climb. the loop is one ram read per level.
// reset is synchronous; the key ram is not cleared; the count, root, state and done are, and capacity resets to 1024.
// busy holds off new starts; the result word cannot be stalled.
`include "max_heap_insert_defines.svh"

module max_heap_insert #(
  parameter int HEAP_DEPTH = 1024
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  mhi_pkg::key_t                       key_value,
  input  logic                                cfg_write,
  input  logic [mhi_pkg::CAP_W-1:0]           capacity_in_use,
  output logic                                done,
  output logic                                insert_status,
  output logic [$clog2(HEAP_DEPTH+1)-1:0]     count_after,
  output logic [$clog2(HEAP_DEPTH)-1:0]       final_slot,
  output mhi_pkg::key_t                       max_key
);

  localparam int AW    = $clog2(HEAP_DEPTH);
  localparam int CW    = $clog2(HEAP_DEPTH + 1);
  localparam int WIDE  = (CW > mhi_pkg::CAP_W) ? CW : mhi_pkg::CAP_W;

  logic [mhi_pkg::CAP_W-1:0] capacity;
  logic [WIDE-1:0]           cap_ext;
  logic [WIDE-1:0]           cap_eff;
  logic                      full;
  logic                      accept;
  logic [CW-1:0]             count;
  mhi_pkg::sift_flags_t      flags;
  logic [AW-1:0]             res_slot;
  mhi_pkg::key_t             res_key;
  mhi_pkg::key_t             root;

  // capacity register
  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= mhi_pkg::CAP_W'(1024);
    end else if (cfg_write) begin
      capacity <= capacity_in_use;
    end
  end

  // effective capacity saturates at the heap depth
  assign cap_ext = WIDE'(capacity);
  assign cap_eff = (cap_ext > WIDE'(HEAP_DEPTH)) ? WIDE'(HEAP_DEPTH) : cap_ext;
  assign full    = (WIDE'(count) >= cap_eff);
  assign accept  = start && !busy;

  mhi_sift #(
    .DEPTH (HEAP_DEPTH),
    .AW    (AW),
    .CW    (CW)
  ) u_sift (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .full     (full),
    .key_in   (key_value),
    .busy     (busy),
    .count    (count),
    .flags    (flags),
    .res_slot (res_slot),
    .res_key  (res_key)
  );

  // result strobe and root copy
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
      root <= '0;
    end else begin
      done <= flags.done;
      if (flags.done && flags.at_root) begin
        root <= res_key;
      end
    end
  end

  // result word payload
  always_ff @(posedge clk) begin
    if (flags.done) begin
      insert_status <= flags.refused;
      final_slot    <= res_slot;
    end
  end

  assign count_after = count;
  assign max_key     = root;

  // checks
  `MHI_ASSERT_NEXT(a_accept_progress, accept, busy || done, "accepted word made no progress")
  `MHI_ASSERT_NOW(a_refused_slot, done && insert_status, final_slot == '0, "refused word slot")
  `MHI_ASSERT_NOW(a_inserted_count, done && !insert_status, count_after != '0,
    "inserted word left heap empty")
  `MHI_ASSERT_NOW(a_count_bound, 1'b1, count_after <= CW'(HEAP_DEPTH), "count above depth")

endmodule
